[hdl/framed_stream_resync_deframer_assert.svh]
// ----------------------------------------------------------------------------
// framed_stream_resync_deframer assertion macros
// shared property forms for the deframer port checks
// ----------------------------------------------------------------------------
`ifndef FRAMED_STREAM_RESYNC_DEFRAMER_ASSERT_SVH
`define FRAMED_STREAM_RESYNC_DEFRAMER_ASSERT_SVH

// condition in one cycle implies a consequence in the next, outside reset
`define FSRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
    else $error("deframer port check failed");

// consequence that must hold in the cycle after reset is seen
`define FSRD_ASSERT_RESET(label, cons) \
    label: assert property (@(posedge i_clk) !i_rst_n |=> (cons)) \
    else $error("deframer reset check failed");

`endif

[hdl/fsrd_pkg.sv]
// ----------------------------------------------------------------------------
// fsrd_pkg
// types and codes shared by the deframer controller, datapath and top level
// ----------------------------------------------------------------------------
package fsrd_pkg;

    typedef struct packed {
        logic [1:0] channel;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_channel;
        logic [7:0] frame_byte;
        logic       frame_first;
        logic       frame_last;
    } t_out_item;

    // buffer read selects
    localparam logic [2:0] RD_HEAD   = 3'd0;
    localparam logic [2:0] RD_LEN_LO = 3'd1;
    localparam logic [2:0] RD_LEN_HI = 3'd2;
    localparam logic [2:0] RD_TAIL   = 3'd3;
    localparam logic [2:0] RD_EMIT   = 3'd4;

    // register indexes
    localparam logic [1:0] REG_HEAD_SIGN = 2'd0;
    localparam logic [1:0] REG_TAIL_SIGN = 2'd1;
    localparam logic [1:0] REG_MAX_LEN   = 2'd2;

    localparam logic [6:0] MAX_LEN_RESET = 7'd64;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       rd_en;
        logic [2:0] rd_sel;
        logic       cap_lo;
        logic       cap_hi;
        logic       drop;
        logic       consume;
        logic       idx_clr;
        logic       emit;
        logic       commit;
    } t_cmd;

    typedef struct packed {
        logic ch_ok;
        logic short_buf;
        logic len_short;
        logic len_fits;
        logic head_match;
        logic len_ok;
        logic len_wait;
        logic tail_match;
        logic last_byte;
        logic out_free;
    } t_sts;

endpackage

[hdl/fsrd_ram.sv]
// ----------------------------------------------------------------------------
// fsrd_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module fsrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/fsrd_ctrl.sv]
// ----------------------------------------------------------------------------
// fsrd_ctrl
// sequencer for append, frame scan, length and tail checks and readout
// ----------------------------------------------------------------------------
module fsrd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fsrd_pkg::t_sts i_sts,
    output fsrd_pkg::t_cmd o_cmd
);
    import fsrd_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_APPEND = 4'd1;
    localparam logic [3:0] S_SCAN   = 4'd2;
    localparam logic [3:0] S_HEAD   = 4'd3;
    localparam logic [3:0] S_LLO    = 4'd4;
    localparam logic [3:0] S_LHI    = 4'd5;
    localparam logic [3:0] S_LCHK   = 4'd6;
    localparam logic [3:0] S_TAIL   = 4'd7;
    localparam logic [3:0] S_ERD    = 4'd8;
    localparam logic [3:0] S_EOUT   = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel = RD_HEAD;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_sts.ch_ok) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_APPEND;
                end
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.short_buf) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_HEAD;
                    n_state      = S_HEAD;
                end
            end
            S_HEAD: begin
                priority if (!i_sts.len_fits || !i_sts.head_match) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_SCAN;
                end else if (i_sts.len_short) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LEN_LO;
                    n_state      = S_LLO;
                end
            end
            S_LLO: begin
                o_cmd.cap_lo = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_LEN_HI;
                n_state      = S_LHI;
            end
            S_LHI: begin
                o_cmd.cap_hi = 1'b1;
                n_state      = S_LCHK;
            end
            S_LCHK: begin
                priority if (!i_sts.len_ok) begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_SCAN;
                end else if (i_sts.len_wait) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_TAIL;
                    n_state      = S_TAIL;
                end
            end
            S_TAIL: begin
                if (i_sts.tail_match) begin
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_ERD;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_ERD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_EMIT;
                n_state      = S_EOUT;
            end
            S_EOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.last_byte) begin
                        o_cmd.consume = 1'b1;
                        n_state       = S_SCAN;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[hdl/fsrd_datapath.sv]
// ----------------------------------------------------------------------------
// fsrd_datapath
// per-channel ring buffers, scan pointers, frame checks and output register
// ----------------------------------------------------------------------------
module fsrd_datapath #(
    parameter int CHANNELS   = 4,
    parameter int BUF_BYTES  = 64,
    parameter int MIN_FRAME  = 4,
    parameter int LEN_OFFSET = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fsrd_pkg::t_in_item i_in_data,
    input  fsrd_pkg::t_cmd     i_cmd,
    output fsrd_pkg::t_sts     o_sts,
    input  logic [7:0]         i_head_sign,
    input  logic [7:0]         i_tail_sign,
    input  logic [6:0]         i_max_frame_len,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output fsrd_pkg::t_out_item o_out_data
);
    import fsrd_pkg::*;

    // only four channels are reachable through a two-bit channel field
    localparam int NCH   = (CHANNELS > 4) ? 4 : CHANNELS;
    localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int HW    = $clog2(BUF_BYTES);
    localparam int FW    = $clog2(BUF_BYTES + 1);
    localparam int SW    = FW + 1;
    localparam int AW    = CIW + HW;
    localparam int DEPTH = 1 << AW;

    logic [FW-1:0] r_fill [NCH];
    logic [HW-1:0] r_head [NCH];

    logic [1:0]    r_ch;
    logic [7:0]    r_byte;
    logic [HW-1:0] r_head_w;
    logic [FW-1:0] r_off;
    logic [FW-1:0] r_remain;
    logic [15:0]   r_len;
    logic [FW-1:0] r_idx;
    logic          r_out_valid;
    t_out_item     r_out;

    logic [SW-1:0] rd_k;
    logic [HW-1:0] rd_pos;
    logic [HW-1:0] wr_pos;
    logic [HW-1:0] end_pos;
    logic [7:0]    rdata;
    logic          full;
    logic          ram_we;
    logic [FW-1:0] len_lo;

    function automatic logic [HW-1:0] wrap(input logic [SW-1:0] a);
        if (a >= SW'(BUF_BYTES)) begin
            return HW'(a - SW'(BUF_BYTES));
        end
        return HW'(a);
    endfunction

    assign len_lo  = r_len[FW-1:0];
    assign full    = (32'(r_remain) == BUF_BYTES);
    assign ram_we  = i_cmd.append && !full;
    assign wr_pos  = wrap(SW'(r_head_w) + SW'(r_remain));
    assign end_pos = wrap(SW'(r_head_w) + SW'(r_off));

    always_comb begin
        case (i_cmd.rd_sel)
            RD_HEAD:   rd_k = SW'(r_off);
            RD_LEN_LO: rd_k = SW'(r_off) + SW'(LEN_OFFSET);
            RD_LEN_HI: rd_k = SW'(r_off) + SW'(LEN_OFFSET + 1);
            RD_TAIL:   rd_k = SW'(r_off) + SW'(len_lo) - SW'(1);
            RD_EMIT:   rd_k = SW'(r_off) + SW'(r_idx);
            default:   rd_k = SW'(r_off);
        endcase
    end

    assign rd_pos = wrap(SW'(r_head_w) + rd_k);

    fsrd_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr ({r_ch[CIW-1:0], wr_pos}),
        .i_wdata (r_byte),
        .i_re    (i_cmd.rd_en),
        .i_raddr ({r_ch[CIW-1:0], rd_pos}),
        .o_rdata (rdata)
    );

    always_comb begin
        o_sts.ch_ok      = (32'(i_in_data.channel) < CHANNELS);
        o_sts.short_buf  = (32'(r_remain) < MIN_FRAME);
        o_sts.len_short  = (32'(r_remain) < LEN_OFFSET + 2);
        o_sts.len_fits   = (LEN_OFFSET + 2 <= BUF_BYTES);
        o_sts.head_match = (rdata == i_head_sign);
        o_sts.len_ok     = (r_len >= 16'(MIN_FRAME)) && (r_len <= {9'd0, i_max_frame_len})
                           && (r_len <= 16'(BUF_BYTES));
        o_sts.len_wait   = (16'(r_remain) < r_len);
        o_sts.tail_match = (rdata == i_tail_sign);
        o_sts.last_byte  = (r_idx == FW'(len_lo - FW'(1)));
        o_sts.out_free   = !r_out_valid || !i_out_stall;
    end

    // channel state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_fill[c] <= '0;
                r_head[c] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_fill[r_ch[CIW-1:0]] <= r_remain;
                r_head[r_ch[CIW-1:0]] <= end_pos;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers of the current item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch     <= i_in_data.channel;
            r_byte   <= i_in_data.data_byte;
            r_head_w <= r_head[i_in_data.channel[CIW-1:0]];
            r_off    <= '0;
            r_remain <= r_fill[i_in_data.channel[CIW-1:0]];
        end
        if (ram_we) begin
            r_remain <= r_remain + FW'(1);
        end
        if (i_cmd.drop) begin
            r_off    <= r_off + FW'(1);
            r_remain <= r_remain - FW'(1);
        end
        if (i_cmd.consume) begin
            r_off    <= r_off + len_lo;
            r_remain <= r_remain - len_lo;
        end
        if (i_cmd.cap_lo) begin
            r_len[7:0] <= rdata;
        end
        if (i_cmd.cap_hi) begin
            r_len[15:8] <= rdata;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end
        if (i_cmd.emit) begin
            r_idx             <= r_idx + FW'(1);
            r_out.out_channel <= r_ch;
            r_out.frame_byte  <= rdata;
            r_out.frame_first <= (r_idx == '0);
            r_out.frame_last  <= o_sts.last_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/framed_stream_resync_deframer.sv]
// ----------------------------------------------------------------------------
// framed_stream_resync_deframer
// multi-channel length-delimited frame deframer with byte resync
// ----------------------------------------------------------------------------
// input channel: one raw byte per beat, tagged with its channel; a byte for a
//   channel at or above CHANNELS is taken and ignored
// output channel: frame bytes, head sign first, with first and last marks
// each byte goes into its channel's ring buffer (dropped when full), then the
//   buffer is scanned from its head: a failed head, length or tail check drops
//   one byte, a frame not yet complete waits for more bytes
// each input beat runs through append, then the head, length and tail checks,
//   then the readout of each frame byte; the single read port of the buffer
//   ram serializes these reads, and no new beat is taken until the buffer
//   holds no complete frame
// o_in_stall is high while a beat is being worked on; a stalled output beat
//   holds in the output register and the readout waits for it
// reset clears fill counts, head pointers and the output valid flag; buffer
//   contents need no clearing pass, and the registers return to head 0, tail 0,
//   max length 64; configuration: apb writes, to be issued only while the block is idle
// ----------------------------------------------------------------------------
module framed_stream_resync_deframer #(
    parameter int CHANNELS   = 4,
    parameter int BUF_BYTES  = 64,
    parameter int MIN_FRAME  = 4,
    parameter int LEN_OFFSET = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fsrd_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fsrd_pkg::t_out_item o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import fsrd_pkg::*;

    logic [7:0] r_head_sign;
    logic [7:0] r_tail_sign;
    logic [6:0] r_max_len;
    logic       cfg_wr;
    t_cmd       cmd;
    t_sts       sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_sign <= '0;
            r_tail_sign <= '0;
            r_max_len   <= MAX_LEN_RESET;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_HEAD_SIGN: r_head_sign <= pwdata[7:0];
                REG_TAIL_SIGN: r_tail_sign <= pwdata[7:0];
                REG_MAX_LEN:   r_max_len   <= pwdata[6:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_HEAD_SIGN: prdata = {24'd0, r_head_sign};
            REG_TAIL_SIGN: prdata = {24'd0, r_tail_sign};
            REG_MAX_LEN:   prdata = {25'd0, r_max_len};
            default:       prdata = '0;
        endcase
    end

    fsrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    fsrd_datapath #(
        .CHANNELS   (CHANNELS),
        .BUF_BYTES  (BUF_BYTES),
        .MIN_FRAME  (MIN_FRAME),
        .LEN_OFFSET (LEN_OFFSET)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_data       (i_in_data),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_head_sign     (r_head_sign),
        .i_tail_sign     (r_tail_sign),
        .i_max_frame_len (r_max_len),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_data      (o_out_data)
    );

endmodule

[hdl/fsrd_checker.sv]
// ----------------------------------------------------------------------------
// fsrd_checker
// port-level checks on the deframer, bound to the top level
// ----------------------------------------------------------------------------
module fsrd_checker #(
    parameter int CHANNELS = 4
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input fsrd_pkg::t_in_item  i_in_data,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fsrd_pkg::t_out_item o_out_data
);
    `include "framed_stream_resync_deframer_assert.svh"

    logic live_beat;
    logic out_held;

    assign live_beat = i_in_valid && !o_in_stall && (32'(i_in_data.channel) < CHANNELS);
    assign out_held  = o_out_valid && i_out_stall;

    // a stalled output beat stays put
    `FSRD_ASSERT_NEXT(a_out_hold, out_held, o_out_valid && $stable(o_out_data))

    // a beat for a live channel always starts a busy period
    `FSRD_ASSERT_NEXT(a_busy_after_beat, live_beat, o_in_stall)

    `FSRD_ASSERT_RESET(a_idle_after_reset, !o_out_valid && !o_in_stall)

endmodule

bind framed_stream_resync_deframer fsrd_checker #(.CHANNELS(CHANNELS)) u_fsrd_checker (.*);
